[hdl/ttts_pkg.sv]
// shared types and constants for the timed task table scheduler
// table entry layout, operation codes, controller states and table sizes
// no dependencies
`default_nettype none

package ttts_pkg;

  localparam int unsigned MAX_TASKS   = 16;
  localparam int unsigned MAX_RESULTS = 16;

  // table index, table fill count and per-tick fire count widths
  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned RES_W = $clog2(MAX_RESULTS + 1);

  // register port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_PRIO_IDX = 1'b0;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_CANCEL  = 3'd1,
    FUNC_CHANGE  = 3'd2,
    FUNC_RESTART = 3'd3,
    FUNC_QUERY   = 3'd4,
    FUNC_TICK    = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  param;
    logic [30:0] interval;
    logic [31:0] last_run;
    logic [7:0]  rep_cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[hdl/ttts_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ttts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/timed_task_table_scheduler_core.sv]
// top level of the timed task table scheduler
// depends on ttts_pkg and ttts_ram
`default_nettype none

// Keeps an ordered table of up to MAX_TASKS timed tasks in one synchronous
// ram (one write port, one registered read port). An add writes the ram
// directly and gives its result without a sweep. Cancel, change interval,
// restart, query and tick walk the table through the ram read port, one entry
// per cycle while the output register is not stalled; the read-modify-write
// sweep writes each kept entry back at a write pointer that trails the read
// pointer, so a removal compacts the table in the same pass. A tick reports each
// fire (at most MAX_RESULTS, only the first in prioritized mode) as its own
// result; the last one of the pass carries last. Results leave through an output
// register, and the sweep holds while that register is full and stalled. No
// clearing pass after reset: only entries below the task count are ever read.

module timed_task_table_scheduler_core
  import ttts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [7:0]            task_id_i,
  input  logic [30:0]           interval_i,
  input  logic [7:0]            repeat_req_i,
  input  logic [7:0]            param_i,
  input  logic [31:0]           now_i,

  // result transaction
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  ok_o,
  output logic                  fired_o,
  output logic [7:0]            fired_id_o,
  output logic [7:0]            fired_param_o,
  output logic                  finished_o,
  output logic                  last_o,

  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // controller state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;   // next entry to read
  logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;   // next slot of the compacted table
  logic             vld_q, vld_d;         // ram read data belongs to the sweep
  logic             found_q, found_d;
  logic [RES_W-1:0] nfire_q, nfire_d;

  // latest fire of the tick, held back until we know whether it is the last
  logic             pend_vld_q, pend_vld_d;
  logic [7:0]       pend_id_q, pend_id_d;
  logic [7:0]       pend_param_q, pend_param_d;
  logic             pend_fin_q, pend_fin_d;

  // latched operation
  func_e            func_q;
  logic [7:0]       id_q;
  logic [30:0]      ivl_q;
  logic [31:0]      now_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q, out_ok_d;
  logic             out_fired_q, out_fired_d;
  logic [7:0]       out_id_q, out_id_d;
  logic [7:0]       out_param_q, out_param_d;
  logic             out_fin_q, out_fin_d;
  logic             out_last_q, out_last_d;

  logic             prio_q;

  // table ram
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  // entry under test
  entry_t           ent, upd;
  logic [31:0]      diff;
  logic             hit, due, fire, fin, drop;

  logic             adv, accept, cfg_wr;

  ttts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output slot free or being emptied this cycle
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && adv);
  assign accept     = in_valid_i && !in_stall_o;

  // per-entry evaluation, wrapping signed time difference
  always_comb begin
    ent  = ram_rdata;
    upd  = ent;
    hit  = (ent.id == id_q) && !found_q;
    diff = now_q - ent.last_run;
    due  = !diff[31] && (diff[30:0] >= ent.interval);
    fire = (func_q == FUNC_TICK) && due && (nfire_q < RES_W'(MAX_RESULTS)) &&
           !(prio_q && (nfire_q != '0));
    fin  = fire && (ent.rep_cnt == 8'd1);
    drop = fin;
    case (func_q)
      FUNC_CANCEL: begin
        drop = hit;
      end
      FUNC_CHANGE: begin
        if (hit) begin
          upd.interval = ivl_q;
        end
      end
      FUNC_RESTART: begin
        if (hit) begin
          upd.last_run = now_q;
        end
      end
      FUNC_TICK: begin
        if (fire) begin
          upd.last_run = ent.last_run + {1'b0, ent.interval};
          if (ent.rep_cnt != 8'd0) begin
            upd.rep_cnt = ent.rep_cnt - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer: next state, ram accesses and result loading
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    vld_d        = vld_q;
    found_d      = found_q;
    nfire_d      = nfire_q;
    pend_vld_d   = pend_vld_q;
    pend_id_d    = pend_id_q;
    pend_param_d = pend_param_q;
    pend_fin_d   = pend_fin_q;

    out_valid_d  = out_valid_q;
    out_ok_d     = out_ok_q;
    out_fired_d  = out_fired_q;
    out_id_d     = out_id_q;
    out_param_d  = out_param_q;
    out_fin_d    = out_fin_q;
    out_last_d   = out_last_q;
    if (adv) begin
      out_valid_d = 1'b0;
    end

    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q[IDX_W-1:0];
    ram_wdata = upd;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_ADD: begin
              out_valid_d = 1'b1;
              out_ok_d    = 1'b0;
              out_fired_d = 1'b0;
              out_id_d    = '0;
              out_param_d = '0;
              out_fin_d   = 1'b0;
              out_last_d  = 1'b1;
              if ((count_q < CNT_W'(MAX_TASKS)) && (interval_i != '0)) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IDX_W-1:0];
                ram_wdata = '{id: task_id_i, param: param_i, interval: interval_i,
                              last_run: now_i, rep_cnt: repeat_req_i};
                count_d   = count_q + CNT_W'(1);
                out_ok_d  = 1'b1;
              end
            end
            FUNC_CANCEL, FUNC_CHANGE, FUNC_RESTART, FUNC_QUERY, FUNC_TICK: begin
              state_d    = ST_SCAN;
              rd_ptr_d   = '0;
              wr_ptr_d   = '0;
              vld_d      = 1'b0;
              found_d    = 1'b0;
              nfire_d    = '0;
              pend_vld_d = 1'b0;
            end
            default: begin
              // unused operation codes: nothing changes
              out_valid_d = 1'b1;
              out_ok_d    = 1'b0;
              out_fired_d = 1'b0;
              out_id_d    = '0;
              out_param_d = '0;
              out_fin_d   = 1'b0;
              out_last_d  = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // process the entry held in the ram read register
          if (vld_q) begin
            if (hit) begin
              found_d = 1'b1;
            end
            if (!drop) begin
              ram_we   = 1'b1;
              wr_ptr_d = wr_ptr_q + CNT_W'(1);
            end
            if (fire) begin
              nfire_d = nfire_q + RES_W'(1);
              if (pend_vld_q) begin
                out_valid_d = 1'b1;
                out_ok_d    = 1'b1;
                out_fired_d = 1'b1;
                out_id_d    = pend_id_q;
                out_param_d = pend_param_q;
                out_fin_d   = pend_fin_q;
                out_last_d  = 1'b0;
              end
              pend_vld_d   = 1'b1;
              pend_id_d    = ent.id;
              pend_param_d = ent.param;
              pend_fin_d   = fin;
            end
          end
          // issue the next read; writes always land below the read pointer
          if (rd_ptr_q < count_q) begin
            ram_re   = 1'b1;
            rd_ptr_d = rd_ptr_q + CNT_W'(1);
            vld_d    = 1'b1;
          end else begin
            vld_d = 1'b0;
            if (!vld_q) begin
              state_d = ST_FINISH;
              count_d = wr_ptr_q;
            end
          end
        end
      end

      ST_FINISH: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if ((func_q == FUNC_TICK) && pend_vld_q) begin
            out_ok_d    = 1'b1;
            out_fired_d = 1'b1;
            out_id_d    = pend_id_q;
            out_param_d = pend_param_q;
            out_fin_d   = pend_fin_q;
          end else begin
            out_ok_d    = (func_q != FUNC_TICK) && found_q;
            out_fired_d = 1'b0;
            out_id_d    = '0;
            out_param_d = '0;
            out_fin_d   = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      vld_q       <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sweep and payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    wr_ptr_q     <= wr_ptr_d;
    found_q      <= found_d;
    nfire_q      <= nfire_d;
    pend_id_q    <= pend_id_d;
    pend_param_q <= pend_param_d;
    pend_fin_q   <= pend_fin_d;
    out_ok_q     <= out_ok_d;
    out_fired_q  <= out_fired_d;
    out_id_q     <= out_id_d;
    out_param_q  <= out_param_d;
    out_fin_q    <= out_fin_d;
    out_last_q   <= out_last_d;
    if (accept) begin
      func_q <= func_e'(func_i);
      id_q   <= task_id_i;
      ivl_q  <= interval_i;
      now_q  <= now_i;
    end
  end

  // register port: prioritized mode at word 0
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRIO_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= 1'b1;
    end else if (cfg_wr) begin
      prio_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_PRIO_IDX) ? {{(CFG_DATA_W-1){1'b0}}, prio_q} : '0;
  assign pready = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign fired_o       = out_fired_q;
  assign fired_id_o    = out_id_q;
  assign fired_param_o = out_param_q;
  assign finished_o    = out_fin_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

[bench/tb_timed_task_table_scheduler_core.sv]
// self-checking bench for timed_task_table_scheduler_core: directed and random table traffic
// predicts every result transaction with a local copy of the task table and compares in order
// depends on ttts_pkg and the scheduler core rtl
`default_nettype none

module tb_timed_task_table_scheduler_core;
  import ttts_pkg::*;

  // run limits
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // quiet cycles after the last result, covers a full table sweep
  localparam int unsigned SETTLE = MAX_TASKS + 8;

  // codes the block treats as no-ops
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // byte address of the prioritized-mode register
  localparam logic [CFG_ADDR_W-1:0] PRIO_ADDR = CFG_ADDR_W'(4 * int'(REG_PRIO_IDX));

  // one operation as offered on the input channel
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  id;
    logic [30:0] ivl;
    logic [7:0]  reps;
    logic [7:0]  param;
    logic [31:0] now;
  } sched_op_t;

  // one result transaction
  typedef struct packed {
    logic       ok;
    logic       fired;
    logic [7:0] id;
    logic [7:0] param;
    logic       finished;
    logic       last;
  } report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [2:0]            func_i;
  logic [7:0]            task_id_i;
  logic [30:0]           interval_i;
  logic [7:0]            repeat_req_i;
  logic [7:0]            param_i;
  logic [31:0]           now_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  ok_o;
  logic                  fired_o;
  logic [7:0]            fired_id_o;
  logic [7:0]            fired_param_o;
  logic                  finished_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the scheduler state
  entry_t      sched_entries [MAX_TASKS];
  int unsigned entry_cnt;
  logic        prio_mode;

  // reports still owed by the block, oldest first
  report_t pending_reports [$];

  int unsigned mismatches;
  int unsigned cycle_cnt;
  logic [31:0] sim_ms;     // running millisecond time for random traffic
  int unsigned hold_left;  // long receiver hold-off, counted down by the stall driver
  bit          tx_quiet;   // sender offers back to back
  bit          rx_quiet;   // receiver never stalls

  timed_task_table_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .task_id_i     (task_id_i),
    .interval_i    (interval_i),
    .repeat_req_i  (repeat_req_i),
    .param_i       (param_i),
    .now_i         (now_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .fired_o       (fired_o),
    .fired_id_o    (fired_id_o),
    .fired_param_o (fired_param_o),
    .finished_o    (finished_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // first entry holding this id, -1 when none
  function automatic int find_entry(logic [7:0] id);
    for (int i = 0; i < int'(entry_cnt); i++)
      if (sched_entries[i].id == id) return i;
    return -1;
  endfunction

  // close the gap left by a removed entry, order of the rest kept
  function automatic void remove_entry(int idx);
    for (int i = idx; i + 1 < int'(entry_cnt); i++)
      sched_entries[i] = sched_entries[i + 1];
    entry_cnt--;
  endfunction

  // apply one accepted operation to the local table and queue its reports
  function automatic void predict_reports(sched_op_t op);
    report_t     batch [$];
    report_t     rep;
    logic [31:0] diff;
    int          idx;
    int          i;
    if (op.func == FUNC_TICK) begin
      i = 0;
      // one time value for the whole pass, at most MAX_RESULTS fires
      while (i < int'(entry_cnt) && batch.size() < MAX_RESULTS) begin
        diff = op.now - sched_entries[i].last_run;
        // due when the wrapped difference is non-negative and covers the interval
        if (!diff[31] && diff >= {1'b0, sched_entries[i].interval}) begin
          rep = '0;
          rep.ok = 1'b1;
          rep.fired = 1'b1;
          rep.id = sched_entries[i].id;
          rep.param = sched_entries[i].param;
          sched_entries[i].last_run = sched_entries[i].last_run
                                      + {1'b0, sched_entries[i].interval};
          // a zero count repeats forever
          if (sched_entries[i].rep_cnt != 8'd0) begin
            sched_entries[i].rep_cnt = sched_entries[i].rep_cnt - 8'd1;
            rep.finished = (sched_entries[i].rep_cnt == 8'd0);
          end
          batch.push_back(rep);
          if (rep.finished) remove_entry(i);
          else i++;
          if (prio_mode) break;
        end else begin
          i++;
        end
      end
      if (batch.size() == 0) begin
        rep = '0;
        rep.last = 1'b1;
        batch.push_back(rep);
      end else begin
        batch[batch.size() - 1].last = 1'b1;
      end
    end else begin
      rep = '0;
      rep.last = 1'b1;
      idx = find_entry(op.id);
      case (op.func)
        FUNC_ADD: begin
          // rejected on a full table or a zero interval
          if (entry_cnt < MAX_TASKS && op.ivl != 31'd0) begin
            sched_entries[entry_cnt] = '{id: op.id, param: op.param, interval: op.ivl,
                                         last_run: op.now, rep_cnt: op.reps};
            entry_cnt++;
            rep.ok = 1'b1;
          end
        end
        FUNC_CANCEL: begin
          if (idx >= 0) begin
            remove_entry(idx);
            rep.ok = 1'b1;
          end
        end
        FUNC_CHANGE: begin
          if (idx >= 0) begin
            sched_entries[idx].interval = op.ivl;
            rep.ok = 1'b1;
          end
        end
        FUNC_RESTART: begin
          if (idx >= 0) begin
            sched_entries[idx].last_run = op.now;
            rep.ok = 1'b1;
          end
        end
        FUNC_QUERY: rep.ok = (idx >= 0);
        default: ;
      endcase
      batch.push_back(rep);
    end
    foreach (batch[k]) pending_reports.push_back(batch[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // every accepted result is matched against the oldest owed report
  always @(posedge clk_i) begin : report_check
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got ok=%0b fired=%0b id=%0h",
                 $time, ok_o, fired_o, fired_id_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("ok", 8'(want.ok), 8'(ok_o));
        check_field("fired", 8'(want.fired), 8'(fired_o));
        check_field("fired_id", want.id, fired_id_o);
        check_field("fired_param", want.param, fired_param_o);
        check_field("finished", 8'(want.finished), 8'(finished_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // idle lengths: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, a long hold-off on request
  initial begin : rx_stall_driver
    int run_left;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else if (out_stall_i || rx_quiet) begin
        out_stall_i <= 1'b0;
        run_left = rx_quiet ? 0 : $urandom_range(0, 12);
      end else begin
        out_stall_i <= 1'b1;
        run_left = pick_gap();
      end
    end
  end

  function automatic sched_op_t make_op(logic [2:0] func, logic [7:0] id, logic [30:0] ivl,
                                        logic [7:0] reps, logic [7:0] param,
                                        logic [31:0] now);
    sched_op_t op;
    op.func = func;
    op.id = id;
    op.ivl = ivl;
    op.reps = reps;
    op.param = param;
    op.now = now;
    return op;
  endfunction

  // offer one transaction, hold it until accepted, then maybe idle a while
  task automatic send_op(sched_op_t op);
    int gap;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= op.func;
    task_id_i    <= op.id;
    interval_i   <= op.ivl;
    repeat_req_i <= op.reps;
    param_i      <= op.param;
    now_i        <= op.now;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    predict_reports(op);
    gap = tx_quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // sender pauses until every owed report is in, then lets the sweep settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write on an idle block: setup cycle then access cycle
  task automatic write_prio(logic [CFG_DATA_W-1:0] value);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PRIO_ADDR;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    prio_mode = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every lookup misses on an empty table, tick fires nothing, spare codes do nothing
  task automatic test_empty_table();
    send_op(make_op(FUNC_QUERY, 8'd0, 31'd0, 8'd0, 8'd0, 32'd0));
    send_op(make_op(FUNC_CANCEL, 8'hFF, 31'd5, 8'd0, 8'd0, 32'd0));
    send_op(make_op(FUNC_CHANGE, 8'd3, 31'd5, 8'd0, 8'd0, 32'd0));
    send_op(make_op(FUNC_RESTART, 8'd3, 31'd0, 8'd0, 8'd0, 32'd100));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
    send_op(make_op(FUNC_SPARE_6, 8'hFF, 31'h7FFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_op(make_op(FUNC_SPARE_7, 8'd1, 31'd1, 8'd1, 8'd1, 32'd1));
    // zero interval add is refused
    send_op(make_op(FUNC_ADD, 8'd9, 31'd0, 8'd1, 8'd9, 32'd0));
  endtask

  // all-ones and all-zeros fields, firing across the signed time boundary
  task automatic test_field_extremes();
    send_op(make_op(FUNC_ADD, 8'hFF, 31'h7FFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_op(make_op(FUNC_ADD, 8'h00, 31'd1, 8'd1, 8'h00, 32'd0));
    send_op(make_op(FUNC_QUERY, 8'hFF, 31'd0, 8'd0, 8'd0, 32'd0));
    // one-shot task fires and is removed
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'd1));
    // difference one below the largest interval, nothing due
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'h7FFF_FFFD));
    // largest interval reached exactly
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'h7FFF_FFFE));
    send_op(make_op(FUNC_CANCEL, 8'hFF, 31'd0, 8'd0, 8'd0, 32'd0));
  endtask

  // duplicate ids, zero interval by change, restart, wrap of the time counter
  task automatic test_lookup_edits();
    send_op(make_op(FUNC_ADD, 8'd7, 31'd100, 8'd0, 8'hA1, 32'd1000));
    send_op(make_op(FUNC_ADD, 8'd7, 31'd50, 8'd2, 8'hA2, 32'd1000));
    send_op(make_op(FUNC_QUERY, 8'd7, 31'd0, 8'd0, 8'd0, 32'd0));
    // first match gets the zero interval, due at once
    send_op(make_op(FUNC_CHANGE, 8'd7, 31'd0, 8'd0, 8'd0, 32'd0));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'd1000));
    send_op(make_op(FUNC_RESTART, 8'd7, 31'd0, 8'd0, 8'd0, 32'd900));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'd899));
    send_op(make_op(FUNC_CANCEL, 8'd7, 31'd0, 8'd0, 8'd0, 32'd0));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'd1050));
    // last run just below the wrap, due just after it
    send_op(make_op(FUNC_ADD, 8'd9, 31'h20, 8'd0, 8'h5A, 32'hFFFF_FFF0));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, 32'h0000_0010));
  endtask

  // fill the table, refuse one more add, then a tick that fires everything
  task automatic test_full_table();
    logic [31:0] base;
    base = 32'h4000_0000 + ($urandom & 32'hFFFF);
    write_prio(32'h0);
    while (entry_cnt < MAX_TASKS)
      send_op(make_op(FUNC_ADD, 8'(entry_cnt + 16), 31'(entry_cnt % 3 + 1),
                      8'(entry_cnt % 3), 8'($urandom), base));
    send_op(make_op(FUNC_ADD, 8'd99, 31'd1, 8'd1, 8'd99, base));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, base + 32'd100));
    send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, base + 32'd100));
  endtask

  // receiver holds off long while the sender keeps offering, block must back up
  task automatic test_backpressure();
    logic [31:0] t;
    t = 32'h0100_0000;
    tx_quiet = 1'b1;
    hold_left = 300;
    for (int n = 0; n < 30; n++) begin
      t = t + 32'd3;
      if (n % 3 == 0)
        send_op(make_op(FUNC_ADD, 8'(n), 31'($urandom_range(1, 6)), 8'($urandom_range(0, 3)),
                        8'($urandom), t));
      else
        send_op(make_op(FUNC_TICK, 8'd0, 31'd0, 8'd0, 8'd0, t));
    end
    tx_quiet = 1'b0;
    drain();
  endtask

  // mostly well-formed traffic on a running clock with a small id pool
  function automatic sched_op_t random_op();
    sched_op_t op;
    int        r;
    r = $urandom_range(0, 99);
    sim_ms = sim_ms + (($urandom_range(0, 19) == 0) ? $urandom_range(100, 5000)
                                                     : $urandom_range(0, 20));
    op.id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    op.param = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80) op.ivl = 31'($urandom_range(1, 40));
    else if (r < 88) op.ivl = 31'd0;
    else op.ivl = 31'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) op.reps = 8'($urandom_range(1, 4));
    else if (r < 85) op.reps = 8'd0;
    else op.reps = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 90) op.now = sim_ms;
    else if (r < 95) op.now = $urandom;
    else op.now = sim_ms - $urandom_range(1, 30);
    r = $urandom_range(0, 99);
    if (r < 25) op.func = FUNC_ADD;
    else if (r < 60) op.func = FUNC_TICK;
    else if (r < 75) op.func = FUNC_CANCEL;
    else if (r < 83) op.func = FUNC_CHANGE;
    else if (r < 90) op.func = FUNC_RESTART;
    else if (r < 97) op.func = FUNC_QUERY;
    else op.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    return op;
  endfunction

  task automatic test_random_traffic(int count, logic [31:0] start_ms);
    sim_ms = start_ms;
    for (int n = 0; n < count; n++) begin
      // new idling pattern every 40 transactions, some stretches fully busy
      if (n % 40 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      send_op(random_op());
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_QUERY;
    task_id_i = '0;
    interval_i = '0;
    repeat_req_i = '0;
    param_i = '0;
    now_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    entry_cnt = 0;
    prio_mode = 1'b1;
    mismatches = 0;
    cycle_cnt = 0;
    sim_ms = '0;
    hold_left = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_field_extremes();
    test_lookup_edits();
    test_full_table();
    test_backpressure();
    // upper data bits are ignored, only bit 0 selects the mode
    write_prio(32'hFFFF_FFFF);
    test_random_traffic(60, $urandom);
    write_prio(32'hFFFF_FFFE);
    test_random_traffic(60, 32'hFFFF_F800);
    write_prio(32'h1);
    test_random_traffic(60, 32'h7FFF_FC00);
    write_prio(32'h0);
    test_random_traffic(60, $urandom);
    drain();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
